// ===== rtl/cltt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltt_pkg
// Shared types and constants of the latest-value transmit table.
// ----------------------------------------------------------------------------
package cltt_pkg;

   // table geometry
   localparam int SLOTS     = 8;
   localparam int MAX_BYTES = 8;
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W     = $clog2(SLOTS + 1);

   // request command codes
   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_SEND  = 1'b1;

   // one stored frame
   typedef struct packed {
      logic        bus;
      logic [10:0] id;
      logic [3:0]  length;
      logic [63:0] payload;
   } slot_type;

   // slot memory access
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_type         wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_ctrl_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEND
   } state_type;

endpackage

// ===== rtl/cltt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltt request and response channels
// Valid/ready channels carrying update/send requests and sent frames.
// ----------------------------------------------------------------------------
interface cltt_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic        bus;
   logic [10:0] frame_id;
   logic [3:0]  byte_count;
   logic [63:0] payload;

   modport source (output valid, command, bus, frame_id, byte_count, payload,
                   input ready);
   modport sink (input valid, command, bus, frame_id, byte_count, payload,
                 output ready);
endinterface

interface cltt_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_bus;
   logic [10:0] out_id;
   logic [3:0]  out_length;
   logic [63:0] out_payload;
   logic        last;
   logic [31:0] errors_seen;

   modport source (output valid, out_bus, out_id, out_length, out_payload, last,
                   errors_seen, input ready);
   modport sink (input valid, out_bus, out_id, out_length, out_payload, last,
                 errors_seen, output ready);
endinterface

// ===== rtl/cltt_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltt_slot_ram
// Slot storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cltt_slot_ram (
   input  logic                  clock,
   input  cltt_pkg::ram_ctrl_type ctrl,
   output cltt_pkg::slot_type     rd_data
);
   import cltt_pkg::*;

   slot_type mem [SLOTS];

   // write port
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
   end

   // read port, registered: data the cycle after the address
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data <= mem[ctrl.rd_addr];
      end
   end

endmodule

// ===== rtl/can_latest_value_tx_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_latest_value_tx_table_unit
// Latest-value transmit table: stores frames by bus and id, sends them all.
// ----------------------------------------------------------------------------
// Update, empty table or bad length: done in ST_IDLE, next request the cycle after.
// Update with n occupied slots: the slot memory is read once per slot, so the
//   request holds off the next one until ST_SCAN has compared every slot.
// Send: slot 0 is read on the request and loaded in ST_SEND, then one frame
//   per cycle while the response side takes them.
// Reset empties the table (fill count zero) and clears the error counter; the
//   slot memory itself is not cleared.
// ----------------------------------------------------------------------------
module can_latest_value_tx_table_unit (
   input logic       clock,
   input logic       reset,
   cltt_req_if.sink  req_ch,
   cltt_rsp_if.source rsp_ch
);
   import cltt_pkg::*;

   localparam logic [3:0] LEN_MAX = 4'(MAX_BYTES);

   // keep bytes below the length, zero the rest
   function automatic logic [63:0] keep_bytes(input logic [63:0] value,
                                              input logic [3:0] len);
      logic [63:0] res;
      res = '0;
      for (int b = 0; b < 8; b++) begin
         if (4'(b) < len) begin
            res[b*8 +: 8] = value[b*8 +: 8];
         end
      end
      return res;
   endfunction

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      error_ff, error_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] send_idx_ff, send_idx_in;
   slot_type         key_ff, key_in;
   logic             rsp_vld_ff, rsp_vld_in;
   slot_type         rsp_slot_ff;
   logic             rsp_last_ff, last_in;
   logic [31:0]      rsp_err_ff;

   ram_ctrl_type     ram;
   slot_type         rd_data;
   slot_type         new_slot;
   logic [CNT_W-1:0] last_idx;
   logic             out_free;
   logic             load;
   logic             match;

   cltt_slot_ram u_ram (
      .clock   (clock),
      .ctrl    (ram),
      .rd_data (rd_data)
   );

   // incoming frame with unused bytes cleared
   always_comb begin
      new_slot.bus     = req_ch.bus;
      new_slot.id      = req_ch.frame_id;
      new_slot.length  = req_ch.byte_count;
      new_slot.payload = keep_bytes(req_ch.payload, req_ch.byte_count);
   end

   assign last_idx = count_ff - CNT_W'(1);
   assign out_free = !rsp_vld_ff || rsp_ch.ready;
   assign match    = (rd_data.bus == key_ff.bus) && (rd_data.id == key_ff.id);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer: next state, memory access and datapath updates
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      send_idx_in  = send_idx_ff;
      key_in       = key_ff;
      load         = 1'b0;
      last_in      = 1'b0;
      ram          = '0;
      req_ch.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.command == CMD_STORE) begin
                  if (req_ch.byte_count > LEN_MAX) begin
                     error_in = error_ff + 32'd1;
                  end else if (count_ff == '0) begin
                     ram.wr_en   = 1'b1;
                     ram.wr_addr = count_ff[IDX_W-1:0];
                     ram.wr_data = new_slot;
                     count_in    = count_ff + CNT_W'(1);
                  end else begin
                     // look for a slot with the same bus and id
                     key_in      = new_slot;
                     hit_in      = 1'b0;
                     ram.rd_en   = 1'b1;
                     ram.rd_addr = '0;
                     chk_vld_in  = 1'b1;
                     chk_idx_in  = '0;
                     issue_in    = CNT_W'(1);
                     state_in    = ST_SCAN;
                  end
               end else if (count_ff != '0) begin
                  ram.rd_en   = 1'b1;
                  ram.rd_addr = '0;
                  send_idx_in = '0;
                  state_in    = ST_SEND;
               end
            end
         end
         ST_SCAN: begin
            // issue one read per cycle over the occupied slots
            if (issue_ff < count_ff) begin
               ram.rd_en   = 1'b1;
               ram.rd_addr = issue_ff[IDX_W-1:0];
               chk_vld_in  = 1'b1;
               chk_idx_in  = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + CNT_W'(1);
            end
            // compare the slot read last cycle
            if (chk_vld_ff) begin
               if (match) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
               end
               if (CNT_W'(chk_idx_ff) == last_idx) begin
                  state_in = ST_IDLE;
                  if (match) begin
                     ram.wr_en   = 1'b1;
                     ram.wr_addr = chk_idx_ff;
                     ram.wr_data = key_ff;
                  end else if (hit_ff) begin
                     ram.wr_en   = 1'b1;
                     ram.wr_addr = hit_idx_ff;
                     ram.wr_data = key_ff;
                  end else if (count_ff < CNT_W'(SLOTS)) begin
                     ram.wr_en   = 1'b1;
                     ram.wr_addr = count_ff[IDX_W-1:0];
                     ram.wr_data = key_ff;
                     count_in    = count_ff + CNT_W'(1);
                  end else begin
                     error_in = error_ff + 32'd1;
                  end
               end
            end
         end
         ST_SEND: begin
            // move the slot just read into the output register
            if (out_free) begin
               load    = 1'b1;
               last_in = (CNT_W'(send_idx_ff) == last_idx);
               if (last_in) begin
                  state_in = ST_IDLE;
               end else begin
                  send_idx_in = send_idx_ff + IDX_W'(1);
                  ram.rd_en   = 1'b1;
                  ram.rd_addr = send_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_vld_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_vld_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         error_ff   <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         error_ff   <= error_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // scan and key registers
   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      send_idx_ff <= send_idx_in;
      key_ff      <= key_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_slot_ff <= rd_data;
         rsp_last_ff <= last_in;
         rsp_err_ff  <= error_ff;
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.out_bus     = rsp_slot_ff.bus;
   assign rsp_ch.out_id      = rsp_slot_ff.id;
   assign rsp_ch.out_length  = rsp_slot_ff.length;
   assign rsp_ch.out_payload = rsp_slot_ff.payload;
   assign rsp_ch.last        = rsp_last_ff;
   assign rsp_ch.errors_seen = rsp_err_ff;

   // fill count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("fill count beyond table size");

   // fill count grows by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) ||
               (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("fill count jumped");

   // table is never written while frames are being sent
   a_no_write_in_send: assert property (@(posedge clock) disable iff (reset)
      ram.wr_en |-> (state_ff != ST_SEND))
      else $error("slot write during send");

   // error counter holds during a send run
   a_err_stable_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |=> $stable(error_ff))
      else $error("error counter moved during send");

   // a frame is loaded only when the output register is free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("response overwritten");

endmodule
